/* rtl/wsd_pkg.sv */
// Shared types and constants of the WebSocket frame deframer.
// No dependencies; imported by every module of the block.
package wsd_pkg;

    // Error codes carried on the result
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OPCODE   = 2'd1;
    localparam logic [1:0] ERR_UNMASKED = 2'd2;

    // One incoming stream byte
    typedef struct packed {
        logic [7:0] stream_byte;
        logic       new_connection;
    } t_in_item;

    // One result
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       has_byte;
        logic       final_fragment;
        logic [3:0] frame_opcode;
        logic       compressed_flag;
        logic       frame_end;
        logic [1:0] error_code;
    } t_result;

    // Classified work item from the parser to the output stage
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] key;
        logic       has_byte;
        logic       fin;
        logic [3:0] opcode;
        logic       rsv1;
        logic       frame_end;
        logic [1:0] error_code;
    } t_cmd;

endpackage

/* rtl/wsd_front.sv */
// Header parser: walks the frame phases one accepted byte per cycle; issues commands.
// Depends on wsd_pkg.
module wsd_front
    import wsd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output logic     o_cmd_push,
    output t_cmd     o_cmd
);

    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_MASK    = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_ERROR   = 3'd5;

    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [3:0] OP_CONT   = 4'd0;
    localparam logic [3:0] OP_TEXT   = 4'd1;
    localparam logic [3:0] OP_BINARY = 4'd2;
    localparam logic [3:0] OP_CLOSE  = 4'd8;
    localparam logic [3:0] OP_PING   = 4'd9;
    localparam logic [3:0] OP_PONG   = 4'd10;

    logic [2:0]  r_phase,    n_phase,    e_phase;
    logic [3:0]  r_len_left, n_len_left, e_len_left;
    logic [63:0] r_remain,   n_remain,   e_remain;
    logic [31:0] r_key,      n_key,      e_key;
    logic [1:0]  r_pos,      n_pos,      e_pos;
    logic        r_fin,      n_fin,      e_fin;
    logic [3:0]  r_opcode,   n_opcode,   e_opcode;
    logic        r_rsv1,     n_rsv1,     e_rsv1;

    logic [7:0]  b;
    logic [6:0]  len7;
    logic [3:0]  hdr_op;
    logic        op_ok;

    assign b      = i_item.stream_byte;
    assign len7   = b[6:0];
    assign hdr_op = b[3:0];
    assign op_ok  = (hdr_op == OP_CONT) || (hdr_op == OP_TEXT) || (hdr_op == OP_BINARY) ||
                    (hdr_op == OP_CLOSE) || (hdr_op == OP_PING) || (hdr_op == OP_PONG);

    always_comb begin
        // new_connection restarts the parser before this byte is handled
        if (i_item.new_connection) begin
            e_phase    = PH_HDR0;
            e_len_left = '0;
            e_remain   = '0;
            e_key      = '0;
            e_pos      = '0;
            e_fin      = 1'b0;
            e_opcode   = '0;
            e_rsv1     = 1'b0;
        end else begin
            e_phase    = r_phase;
            e_len_left = r_len_left;
            e_remain   = r_remain;
            e_key      = r_key;
            e_pos      = r_pos;
            e_fin      = r_fin;
            e_opcode   = r_opcode;
            e_rsv1     = r_rsv1;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_len_left = r_len_left;
        n_remain   = r_remain;
        n_key      = r_key;
        n_pos      = r_pos;
        n_fin      = r_fin;
        n_opcode   = r_opcode;
        n_rsv1     = r_rsv1;
        o_cmd_push = 1'b0;
        o_cmd      = '0;
        if (i_accept) begin
            n_phase    = e_phase;
            n_len_left = e_len_left;
            n_remain   = e_remain;
            n_key      = e_key;
            n_pos      = e_pos;
            n_fin      = e_fin;
            n_opcode   = e_opcode;
            n_rsv1     = e_rsv1;
            unique case (e_phase)
                PH_HDR1: begin
                    if (!b[7]) begin
                        n_phase          = PH_ERROR;
                        o_cmd_push       = 1'b1;
                        o_cmd.frame_end  = 1'b1;
                        o_cmd.error_code = ERR_UNMASKED;
                    end else begin
                        n_pos = '0;
                        n_key = '0;
                        if (len7 < LEN_EXT16) begin
                            n_remain = {57'd0, len7};
                            n_phase  = PH_MASK;
                        end else begin
                            n_remain   = '0;
                            n_len_left = (len7 == LEN_EXT64) ? 4'd8 : 4'd2;
                            n_phase    = PH_EXTLEN;
                        end
                    end
                end
                PH_EXTLEN: begin
                    n_remain   = {e_remain[55:0], b};
                    n_len_left = e_len_left - 4'd1;
                    if (n_len_left == 4'd0) begin
                        n_phase = PH_MASK;
                    end
                end
                PH_MASK: begin
                    n_key = {e_key[23:0], b};
                    n_pos = e_pos + 2'd1;
                    if (n_pos == 2'd0) begin
                        if (e_remain == 64'd0) begin
                            // empty payload: one closing result without a byte
                            n_phase         = PH_HDR0;
                            o_cmd_push      = 1'b1;
                            o_cmd.frame_end = 1'b1;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_pos           = e_pos + 2'd1;
                    n_remain        = e_remain - 64'd1;
                    o_cmd_push      = 1'b1;
                    o_cmd.data      = b;
                    o_cmd.key       = e_key[{~e_pos, 3'b000} +: 8];
                    o_cmd.has_byte  = 1'b1;
                    o_cmd.frame_end = (n_remain == 64'd0);
                    if (n_remain == 64'd0) begin
                        n_phase = PH_HDR0;
                    end
                end
                PH_ERROR: begin
                    // bytes dropped until a new connection
                end
                default: begin
                    n_fin      = b[7];
                    n_rsv1     = b[6];
                    n_opcode   = hdr_op;
                    n_len_left = '0;
                    n_remain   = '0;
                    n_key      = '0;
                    n_pos      = '0;
                    if (!op_ok) begin
                        n_phase          = PH_ERROR;
                        o_cmd_push       = 1'b1;
                        o_cmd.frame_end  = 1'b1;
                        o_cmd.error_code = ERR_OPCODE;
                    end else begin
                        n_phase = PH_HDR1;
                    end
                end
            endcase
            o_cmd.fin    = n_fin;
            o_cmd.opcode = n_opcode;
            o_cmd.rsv1   = n_rsv1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HDR0;
            r_len_left <= '0;
            r_remain   <= '0;
            r_key      <= '0;
            r_pos      <= '0;
            r_fin      <= 1'b0;
            r_opcode   <= '0;
            r_rsv1     <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_len_left <= n_len_left;
            r_remain   <= n_remain;
            r_key      <= n_key;
            r_pos      <= n_pos;
            r_fin      <= n_fin;
            r_opcode   <= n_opcode;
            r_rsv1     <= n_rsv1;
        end
    end

endmodule

/* rtl/wsd_cmdq.sv */
// Short command queue between the parser and the output stage.
// Depends on wsd_pkg.
module wsd_cmdq
    import wsd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

/* rtl/wsd_back.sv */
// Output stage: unmasks payload bytes and holds the result register.
// Depends on wsd_pkg.
module wsd_back
    import wsd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_empty,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    input  logic    i_pop,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result, n_result;

    // refill whenever the register is free or is being drained this cycle
    assign o_cmd_pop = !i_cmd_empty && (!r_valid || i_pop);
    assign o_valid   = r_valid;
    assign o_result  = r_result;

    always_comb begin
        n_result.payload_byte    = i_cmd.data ^ i_cmd.key;
        n_result.has_byte        = i_cmd.has_byte;
        n_result.final_fragment  = i_cmd.fin;
        n_result.frame_opcode    = i_cmd.opcode;
        n_result.compressed_flag = i_cmd.rsv1;
        n_result.frame_end       = i_cmd.frame_end;
        n_result.error_code      = i_cmd.error_code;
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_cmd_pop) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

endmodule

/* rtl/websocket_frame_deframer_top.sv */
// WebSocket frame deframer (client-to-server), one stream byte per transfer.
// Throughput: one byte per cycle while full is low; the header parser phase is registered.
// A result reaches the ports through the command queue and then the result register,
// and is taken there by a result transfer.
// Up to CMDQ_DEPTH + 1 results can wait while the consumer stalls before full rises.
// Reset: synchronous, active low; parser returns to frame start, queue and result empty.
module websocket_frame_deframer_top
    import wsd_pkg::*;
#(
    parameter int CMDQ_DEPTH = 4
)
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    // input side: byte transfer when push && !full
    input  logic     push,
    output logic     full,
    input  t_in_item i_item,
    // result side: result transfer when pop && !empty
    output logic     empty,
    input  logic     pop,
    output t_result  o_result
);

    // Front: the header parser classifies each byte and issues at most one
    // command. Header bytes issue none; errors, empty frames and payload
    // bytes issue one each.
    logic accept;
    logic cmd_push;
    t_cmd cmd_in;

    // Queue between parser and output stage so each side stalls on its own.
    logic cmd_full;
    logic cmd_empty;
    logic cmd_pop;
    t_cmd cmd_out;

    logic res_valid;

    assign full   = cmd_full;
    assign accept = push && !cmd_full;
    assign empty  = !res_valid;

    wsd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    wsd_cmdq #(
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_empty (cmd_empty),
        .o_cmd   (cmd_out)
    );

    // Back: XOR unmasking into the result register, refilled in the same
    // cycle a result transfer drains it.
    wsd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_valid     (res_valid),
        .o_result    (o_result)
    );

`ifndef SYNTH
    // Parser never issues a command without a byte transfer.
    a_push_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_push |-> accept)
        else $error("command issued without a byte transfer");

    // A result without a byte always closes the frame and carries a zero byte.
    a_nobyte_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.has_byte) |-> (o_result.frame_end &&
                                            o_result.payload_byte == 8'd0))
        else $error("byteless result not closing its frame");

    // Error results never carry a payload byte.
    a_err_nobyte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.error_code != ERR_NONE) |-> !o_result.has_byte)
        else $error("error result carries a byte");

    // A command popped from the queue is visible as a result next cycle.
    a_pop_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |=> !empty)
        else $error("popped command did not reach the result register");
`endif

endmodule

/* tb/sv/tb_websocket_frame_deframer_top.sv */
// Testbench for websocket_frame_deframer_top: byte-stream frame parsing and unmasking.
// Depends on wsd_pkg (item/result structs, error codes) and the deframer RTL only.
// Self-checking: an in-bench frame predictor queues expected results per accepted byte.
`timescale 1ns / 1ps

module tb_websocket_frame_deframer_top;
    import wsd_pkg::*;

    // Opcodes the parser accepts; anything else is a protocol error
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;
    localparam logic [3:0] VALID_OPS [6] = '{OP_CONT, OP_TEXT, OP_BINARY,
                                             OP_CLOSE, OP_PING, OP_PONG};

    // Header length encodings
    localparam int LEN_7BIT  = 0;
    localparam int LEN_16BIT = 1;
    localparam int LEN_64BIT = 2;

    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;
    localparam int unsigned NO_CUT     = 32'hFFFF_FFFF;
    localparam int          MAX_PRINTS = 60;

    // Parser phases of the predictor
    typedef enum logic [2:0] {
        ST_HDR0, ST_HDR1, ST_EXTLEN, ST_MASK, ST_PAYLOAD, ST_ERROR
    } t_parse_state;

    // ------------------------------------------------------------------
    // DUT signals; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     push    = 1'b0;
    logic     full;
    t_in_item i_item  = '0;
    logic     empty;
    logic     pop     = 1'b0;
    t_result  o_result;

    websocket_frame_deframer_top uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop; far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Frame predictor state
    // ------------------------------------------------------------------
    t_parse_state parse_st;
    logic [3:0]   ext_len_left;
    logic [63:0]  payload_left;
    logic [31:0]  mask_word;
    logic [1:0]   mask_idx;
    logic         cur_fin;
    logic [3:0]   cur_opcode;
    logic         cur_rsv1;

    t_result      pending_deframed [$];   // expected results, oldest first
    int           mismatch_count = 0;
    int           bytes_sent     = 0;
    int           tx_idle_pct    = 0;
    int           rx_idle_pct    = 0;

    function automatic logic is_valid_op(input logic [3:0] op);
        foreach (VALID_OPS[k])
            if (VALID_OPS[k] == op)
                return 1'b1;
        return 1'b0;
    endfunction

    // Same clear as reset; also applied when a byte carries new_connection
    task automatic clear_parser();
        parse_st     = ST_HDR0;
        ext_len_left = '0;
        payload_left = '0;
        mask_word    = '0;
        mask_idx     = '0;
        cur_fin      = 1'b0;
        cur_opcode   = '0;
        cur_rsv1     = 1'b0;
    endtask

    // Result fields of the frame being parsed ride along on every result
    task automatic queue_result(input logic [7:0] data, input logic has,
                                input logic last, input logic [1:0] err);
        t_result r;
        r.payload_byte    = data;
        r.has_byte        = has;
        r.final_fragment  = cur_fin;
        r.frame_opcode    = cur_opcode;
        r.compressed_flag = cur_rsv1;
        r.frame_end       = last;
        r.error_code      = err;
        pending_deframed.push_back(r);
    endtask

    // Advance the parser by one stream byte, queueing the result it causes
    task automatic deframe_byte(input t_in_item it);
        logic [7:0] b;
        logic [7:0] key_byte;
        b = it.stream_byte;
        if (it.new_connection)
            clear_parser();
        case (parse_st)
            ST_HDR1: begin
                if (!b[7]) begin
                    // client frames must be masked
                    parse_st = ST_ERROR;
                    queue_result(8'h00, 1'b0, 1'b1, ERR_UNMASKED);
                end else begin
                    mask_idx  = '0;
                    mask_word = '0;
                    if (b[6:0] < LEN_CODE_16) begin
                        payload_left = {57'd0, b[6:0]};
                        parse_st     = ST_MASK;
                    end else begin
                        payload_left = '0;
                        ext_len_left = (b[6:0] == LEN_CODE_16) ? 4'd2 : 4'd8;
                        parse_st     = ST_EXTLEN;
                    end
                end
            end
            ST_EXTLEN: begin
                payload_left = {payload_left[55:0], b};
                ext_len_left = ext_len_left - 4'd1;
                if (ext_len_left == 4'd0)
                    parse_st = ST_MASK;
            end
            ST_MASK: begin
                mask_word = {mask_word[23:0], b};
                mask_idx  = mask_idx + 2'd1;
                if (mask_idx == 2'd0) begin
                    if (payload_left == 64'd0) begin
                        parse_st = ST_HDR0;
                        queue_result(8'h00, 1'b0, 1'b1, ERR_NONE);
                    end else begin
                        parse_st = ST_PAYLOAD;
                    end
                end
            end
            ST_PAYLOAD: begin
                key_byte     = mask_word[8 * (3 - mask_idx) +: 8];
                mask_idx     = mask_idx + 2'd1;
                payload_left = payload_left - 64'd1;
                if (payload_left == 64'd0)
                    parse_st = ST_HDR0;
                queue_result(b ^ key_byte, 1'b1, payload_left == 64'd0, ERR_NONE);
            end
            ST_ERROR: begin
                // dropped until the next connection
            end
            default: begin
                cur_fin      = b[7];
                cur_rsv1     = b[6];
                cur_opcode   = b[3:0];
                ext_len_left = '0;
                payload_left = '0;
                mask_word    = '0;
                mask_idx     = '0;
                if (!is_valid_op(b[3:0])) begin
                    parse_st = ST_ERROR;
                    queue_result(8'h00, 1'b0, 1'b1, ERR_OPCODE);
                end else begin
                    parse_st = ST_HDR1;
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result side: random pop, compare every transfer with the oldest
    // expectation. pop is sampled at the edge, then redrawn for the next one.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("%0t mismatch: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_deframed.size() == 0) begin
                report_mismatch($sformatf("result %h with none expected", o_result));
            end else begin
                want = pending_deframed.pop_front();
                if (o_result.payload_byte !== want.payload_byte)
                    report_mismatch($sformatf("payload_byte %h, want %h",
                                              o_result.payload_byte, want.payload_byte));
                if (o_result.has_byte !== want.has_byte)
                    report_mismatch($sformatf("has_byte %b, want %b",
                                              o_result.has_byte, want.has_byte));
                if (o_result.final_fragment !== want.final_fragment)
                    report_mismatch($sformatf("final_fragment %b, want %b",
                                              o_result.final_fragment, want.final_fragment));
                if (o_result.frame_opcode !== want.frame_opcode)
                    report_mismatch($sformatf("frame_opcode %h, want %h",
                                              o_result.frame_opcode, want.frame_opcode));
                if (o_result.compressed_flag !== want.compressed_flag)
                    report_mismatch($sformatf("compressed_flag %b, want %b",
                                              o_result.compressed_flag, want.compressed_flag));
                if (o_result.frame_end !== want.frame_end)
                    report_mismatch($sformatf("frame_end %b, want %b",
                                              o_result.frame_end, want.frame_end));
                if (o_result.error_code !== want.error_code)
                    report_mismatch($sformatf("error_code %0d, want %0d",
                                              o_result.error_code, want.error_code));
            end
        end
        pop <= ($urandom_range(99) >= rx_idle_pct);
    end

    // ------------------------------------------------------------------
    // Input side. push is left high after a transfer, so back-to-back
    // bytes never lower and raise it within one time step.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic nc);
        t_in_item it;
        it.stream_byte    = b;
        it.new_connection = nc;
        if ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do
            @(posedge i_clk);
        while (full);
        // transfer happened at this edge
        deframe_byte(it);
        bytes_sent++;
    endtask

    // Header, optional extended length, random key, then up to cut payload bytes
    task automatic send_frame(input logic [7:0] first_byte, input logic [63:0] length,
                              input int form, input int unsigned cut, input logic nc);
        logic [31:0]  key;
        longint unsigned n_payload;
        key = $urandom;
        send_byte(first_byte, nc);
        case (form)
            LEN_16BIT: begin
                send_byte({1'b1, LEN_CODE_16}, 1'b0);
                send_byte(length[15:8], 1'b0);
                send_byte(length[7:0], 1'b0);
            end
            LEN_64BIT: begin
                send_byte({1'b1, LEN_CODE_64}, 1'b0);
                for (int k = 7; k >= 0; k--)
                    send_byte(length[8 * k +: 8], 1'b0);
            end
            default: send_byte({1'b1, length[6:0]}, 1'b0);
        endcase
        for (int k = 3; k >= 0; k--)
            send_byte(key[8 * k +: 8], 1'b0);
        n_payload = (length < 64'(cut)) ? length : 64'(cut);
        for (longint unsigned k = 0; k < n_payload; k++)
            send_byte(8'($urandom_range(255)), 1'b0);
    endtask

    function automatic logic [7:0] random_first_byte(input logic [3:0] op);
        logic [2:0] flags;
        flags = 3'($urandom_range(7));  // fin, rsv1 and the ignored rsv2; the ignored rsv3 is drawn apart
        return {flags, $urandom_range(1) == 1, op};
    endfunction

    // Stall the sender until the block has handed over everything expected
    task automatic hold_until_drained();
        push <= 1'b0;
        while (pending_deframed.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Header corner cases: empty payload, bad opcode and the dropped tail,
    // unmasked frame, 16-bit length, and a short close frame.
    task automatic test_directed();
        send_frame({1'b1, 1'b1, 2'b00, OP_PING}, 64'd0, LEN_7BIT, NO_CUT, 1'b1);
        send_byte({1'b0, 1'b1, 2'b11, 4'hF}, 1'b0);   // opcode 15 -> error
        send_byte(8'hFF, 1'b0);                       // discarded after error
        send_byte({1'b1, 3'b000, OP_BINARY}, 1'b1);   // fresh connection
        send_byte(8'h7F, 1'b0);                       // mask bit clear -> error
        send_frame({1'b1, 3'b000, OP_TEXT}, 64'd1, LEN_16BIT, NO_CUT, 1'b1);
        send_frame({1'b0, 3'b000, OP_CLOSE}, 64'd3, LEN_7BIT, NO_CUT, 1'b0);
    endtask

    // Mostly well-formed frames with random content; the rest is broken
    // headers, frames cut short by a new connection, and raw noise.
    task automatic test_random_stream(input int tx_pct, input int rx_pct, input int n_bytes);
        int          stop_at;
        int          sel;
        int          form;
        logic [63:0] length;
        logic [3:0]  op;
        logic        nc;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stop_at     = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            // a frame only parses from frame start, so reopen the connection if needed
            nc  = (parse_st != ST_HDR0) || ($urandom_range(9) == 0);
            sel = $urandom_range(99);
            if (sel < 70) begin
                sel = $urandom_range(99);
                if (sel < 60) begin
                    form   = LEN_7BIT;
                    length = 64'($urandom_range(0, 12));
                end else if (sel < 75) begin
                    form   = LEN_7BIT;
                    length = 64'($urandom_range(13, 125));
                end else if (sel < 90) begin
                    form   = LEN_16BIT;
                    length = $urandom_range(1) ? 64'($urandom_range(0, 20))
                                               : 64'($urandom_range(126, 260));
                end else begin
                    form   = LEN_64BIT;
                    length = 64'($urandom_range(0, 20));
                end
                op = VALID_OPS[$urandom_range(5)];
                send_frame(random_first_byte(op), length, form, NO_CUT, nc);
            end else if (sel < 80) begin
                do
                    op = 4'($urandom_range(15));
                while (is_valid_op(op));
                send_byte(random_first_byte(op), nc);
                repeat ($urandom_range(0, 3))
                    send_byte(8'($urandom_range(255)), 1'b0);
            end else if (sel < 88) begin
                send_byte(random_first_byte(VALID_OPS[$urandom_range(5)]), nc);
                send_byte({1'b0, 7'($urandom_range(127))}, 1'b0);
                repeat ($urandom_range(0, 3))
                    send_byte(8'($urandom_range(255)), 1'b0);
            end else if (sel < 95) begin
                // huge 64-bit length (top bit included), abandoned mid-payload
                length = {$urandom, $urandom};
                send_frame(random_first_byte(VALID_OPS[$urandom_range(5)]), length,
                           LEN_64BIT, $urandom_range(0, 6), nc);
            end else begin
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        clear_parser();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_stream(35, 56, 260);
        hold_until_drained();
        test_random_stream(56, 35, 260);
        test_random_stream(0, 0, 260);

        // all bytes in: wait out the results still owed, then the pipeline depth
        push <= 1'b0;
        while (pending_deframed.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatch_count == 0 && pending_deframed.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
